>>> hdl/rmth_pkg.sv
// Shared types and constants for the running median unit.
`timescale 1ns / 1ps
package rmth_pkg;

  localparam int HALF_DEPTH_DEF   = 512;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Operation broadcast to every cell of a sorted chain.
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REPLACE = 2'd2
  } op_e;

  // Status that one cell shows its neighbors.
  typedef struct packed {
    logic vld;    // cell holds an entry
    logic stays;  // entry ranks strictly ahead of the broadcast value
    logic bound;  // end of the chain, not a real cell
  } link_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } st_e;

endpackage

>>> hdl/running_median_two_heaps_unit.sv
// Top level of the running median unit: two sorted cell chains and control.
//
//   channel | dir | tdata (low bit up)               | tuser
//   in_     | in  | sample                           | -
//   out_    | out | median_x2, stored_count, zeros   | rejected
//
// For each item the accept cycle picks the chain operations, and the
// update cycle then updates both chains at once and loads the output register.
// The update cycle waits while a previous result sits untaken in the output
// register; input is taken again once the update is done.
// No clearing pass after reset: every cell has a valid bit cleared by reset.
`timescale 1ns / 1ps
module running_median_two_heaps_unit #(
  parameter int HALF_DEPTH   = rmth_pkg::HALF_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // median_x2, stored_count, zero fill
  output logic [((SAMPLE_WIDTH+1+$clog2(2*HALF_DEPTH+1)+7)/8)*8-1:0] out_tdata,
  // rejected
  output logic                                       out_tuser
);

  localparam int HW    = $clog2(HALF_DEPTH + 1);
  localparam int CW    = $clog2(2 * HALF_DEPTH + 1);
  localparam int MW    = SAMPLE_WIDTH + 1;
  localparam int OUT_W = ((MW + CW + 7) / 8) * 8;
  localparam logic [CW-1:0] FULL_CNT = CW'(2 * HALF_DEPTH);

  rmth_pkg::st_e state_r, state_nxt;

  logic signed [SAMPLE_WIDTH-1:0] lo_head, up_head, lo_head_nxt, up_head_nxt;
  logic signed [SAMPLE_WIDTH-1:0] lo_v_r, lo_v_nxt, up_v_r, up_v_nxt;
  rmth_pkg::op_e                  lo_op_r, lo_op_nxt, up_op_r, up_op_nxt;
  rmth_pkg::op_e                  lo_op, up_op;
  logic [HW-1:0]                  lcnt_r, lcnt_nxt, ucnt_r, ucnt_nxt;
  logic signed [MW-1:0]           med_r, med_nxt;
  logic                           rej_r, rej_nxt;
  logic [CW-1:0]                  total;
  logic signed [SAMPLE_WIDTH-1:0] s;
  logic signed [MW-1:0]           s2;
  logic                           gt;
  logic                           accept, out_free, apply;
  logic                           out_valid_r;
  logic [OUT_W-1:0]               out_data_r;
  logic                           out_rej_r;

  assign s        = in_tdata[SAMPLE_WIDTH-1:0];
  assign s2       = {s, 1'b0};
  assign gt       = s2 > med_r;
  assign total    = CW'(lcnt_r) + CW'(ucnt_r);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmth_pkg::ST_IDLE:  if (in_tvalid) state_nxt = rmth_pkg::ST_APPLY;
      rmth_pkg::ST_APPLY: if (out_free)  state_nxt = rmth_pkg::ST_IDLE;
      default:            state_nxt = rmth_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    apply     = 1'b0;
    case (state_r)
      rmth_pkg::ST_IDLE:  in_tready = 1'b1;
      rmth_pkg::ST_APPLY: apply     = out_free;
      default: begin
        in_tready = 1'b0;
        apply     = 1'b0;
      end
    endcase
  end

  // Pick the chain operations and the new half sizes for an accepted item.
  always_comb begin
    lo_op_nxt = rmth_pkg::OP_HOLD;
    up_op_nxt = rmth_pkg::OP_HOLD;
    lo_v_nxt  = s;
    up_v_nxt  = s;
    lcnt_nxt  = lcnt_r;
    ucnt_nxt  = ucnt_r;
    rej_nxt   = 1'b0;
    if (total == FULL_CNT) begin
      rej_nxt = 1'b1;
    end else if (lcnt_r == ucnt_r) begin
      if (gt) begin
        up_op_nxt = rmth_pkg::OP_INSERT;
        ucnt_nxt  = ucnt_r + HW'(1);
      end else begin
        lo_op_nxt = rmth_pkg::OP_INSERT;
        lcnt_nxt  = lcnt_r + HW'(1);
      end
    end else if (ucnt_r > lcnt_r) begin
      lcnt_nxt = lcnt_r + HW'(1);
      if (gt) begin
        // Upper top moves down and the sample takes its place.
        up_op_nxt = rmth_pkg::OP_REPLACE;
        lo_op_nxt = rmth_pkg::OP_INSERT;
        lo_v_nxt  = up_head;
      end else begin
        lo_op_nxt = rmth_pkg::OP_INSERT;
      end
    end else begin
      ucnt_nxt = ucnt_r + HW'(1);
      if (gt) begin
        up_op_nxt = rmth_pkg::OP_INSERT;
      end else begin
        lo_op_nxt = rmth_pkg::OP_REPLACE;
        up_op_nxt = rmth_pkg::OP_INSERT;
        up_v_nxt  = lo_head;
      end
    end
  end

  assign lo_op = apply ? lo_op_r : rmth_pkg::OP_HOLD;
  assign up_op = apply ? up_op_r : rmth_pkg::OP_HOLD;

  rmth_chain #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .HALF_DEPTH  (HALF_DEPTH),
    .MAX_FIRST   (1'b1)
  ) u_lower (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (lo_op),
    .v       (lo_v_r),
    .head_val(lo_head),
    .head_nxt(lo_head_nxt)
  );

  rmth_chain #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .HALF_DEPTH  (HALF_DEPTH),
    .MAX_FIRST   (1'b0)
  ) u_upper (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (up_op),
    .v       (up_v_r),
    .head_val(up_head),
    .head_nxt(up_head_nxt)
  );

  // Counts already hold the sizes after this item during the update cycle.
  always_comb begin
    if (rej_r) begin
      med_nxt = med_r;
    end else if (lcnt_r == ucnt_r) begin
      med_nxt = MW'(lo_head_nxt) + MW'(up_head_nxt);
    end else if (lcnt_r > ucnt_r) begin
      med_nxt = {lo_head_nxt, 1'b0};
    end else begin
      med_nxt = {up_head_nxt, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmth_pkg::ST_IDLE;
      lcnt_r      <= '0;
      ucnt_r      <= '0;
      med_r       <= '0;
      lo_op_r     <= rmth_pkg::OP_HOLD;
      up_op_r     <= rmth_pkg::OP_HOLD;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        lcnt_r  <= lcnt_nxt;
        ucnt_r  <= ucnt_nxt;
        lo_op_r <= lo_op_nxt;
        up_op_r <= up_op_nxt;
        rej_r   <= rej_nxt;
      end
      if (apply) begin
        med_r       <= med_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_v_r <= lo_v_nxt;
      up_v_r <= up_v_nxt;
    end
    if (apply) begin
      out_data_r <= OUT_W'({total, med_nxt});
      out_rej_r  <= rej_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rej_r;

  // The halves never differ in size by more than one.
  a_balance : assert property (@(posedge clk) disable iff (!rst_n)
    (lcnt_r == ucnt_r) || ({1'b0, lcnt_r} == {1'b0, ucnt_r} + (HW+1)'(1)) ||
    ({1'b0, ucnt_r} == {1'b0, lcnt_r} + (HW+1)'(1)))
    else $error("half sizes out of balance");

  // Every entry of the lower half ranks at or below every upper entry.
  a_order : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmth_pkg::ST_IDLE) && (lcnt_r != '0) && (ucnt_r != '0)
      |-> (lo_head <= up_head))
    else $error("lower top above upper top");

  // A result appears only from an update cycle.
  a_out_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(apply))
    else $error("result without update");

  // The store never grows past its capacity.
  a_cap : assert property (@(posedge clk) disable iff (!rst_n)
    total <= FULL_CNT)
    else $error("store count beyond capacity");

endmodule

>>> hdl/rmth_cell.sv
// One cell of a sorted chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module rmth_cell #(
  parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF,
  parameter bit MAX_FIRST    = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rmth_pkg::op_e                  op,
  input  logic signed [SAMPLE_WIDTH-1:0] v,
  input  logic signed [SAMPLE_WIDTH-1:0] left_val,
  input  rmth_pkg::link_t                left_lnk,
  input  logic signed [SAMPLE_WIDTH-1:0] right_val,
  input  rmth_pkg::link_t                right_lnk,
  output logic signed [SAMPLE_WIDTH-1:0] own_val,
  output rmth_pkg::link_t                own_lnk,
  output logic signed [SAMPLE_WIDTH-1:0] nxt_val
);

  logic signed [SAMPLE_WIDTH-1:0] val_r;
  logic signed [SAMPLE_WIDTH-1:0] val_nxt;
  logic                           vld_r;
  logic                           vld_nxt;
  logic                           stays;

  assign stays = vld_r && (MAX_FIRST ? (val_r > v) : (val_r < v));

  assign own_val = val_r;
  assign own_lnk = '{vld: vld_r, stays: stays, bound: 1'b0};
  assign nxt_val = val_nxt;

  // Insert shifts entries that rank behind v one place away from the head.
  // Replace drops the head, pulls the entries that rank ahead of v one place in and slots v.
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    case (op)
      rmth_pkg::OP_INSERT: begin
        if (stays) begin
          val_nxt = val_r;
          vld_nxt = 1'b1;
        end else if (left_lnk.stays) begin
          val_nxt = v;
          vld_nxt = 1'b1;
        end else begin
          val_nxt = left_val;
          vld_nxt = left_lnk.vld;
        end
      end
      rmth_pkg::OP_REPLACE: begin
        if (right_lnk.stays) begin
          val_nxt = right_val;
          vld_nxt = 1'b1;
        end else if (left_lnk.bound || stays) begin
          val_nxt = v;
          vld_nxt = 1'b1;
        end else begin
          val_nxt = val_r;
          vld_nxt = vld_r;
        end
      end
      default: begin
        val_nxt = val_r;
        vld_nxt = vld_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> hdl/rmth_chain.sv
// Row of cells that keeps one half sorted with its best entry at the head.
`timescale 1ns / 1ps
module rmth_chain #(
  parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF,
  parameter int HALF_DEPTH   = rmth_pkg::HALF_DEPTH_DEF,
  parameter bit MAX_FIRST    = 1'b0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rmth_pkg::op_e                  op,
  input  logic signed [SAMPLE_WIDTH-1:0] v,
  output logic signed [SAMPLE_WIDTH-1:0] head_val,
  output logic signed [SAMPLE_WIDTH-1:0] head_nxt
);

  logic signed [SAMPLE_WIDTH-1:0] val_w [HALF_DEPTH];
  rmth_pkg::link_t                lnk_w [HALF_DEPTH];

  localparam rmth_pkg::link_t HEAD_LNK = '{vld: 1'b1, stays: 1'b1, bound: 1'b1};
  localparam rmth_pkg::link_t TAIL_LNK = '{vld: 1'b0, stays: 1'b0, bound: 1'b1};

  assign head_val = val_w[0];

  for (genvar i = 0; i < HALF_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      rmth_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .MAX_FIRST   (MAX_FIRST)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .v        (v),
        .left_val ('0),
        .left_lnk (HEAD_LNK),
        .right_val(val_w[1]),
        .right_lnk(lnk_w[1]),
        .own_val  (val_w[0]),
        .own_lnk  (lnk_w[0]),
        .nxt_val  (head_nxt)
      );
    end else if (i == HALF_DEPTH - 1) begin : g_tail
      rmth_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .MAX_FIRST   (MAX_FIRST)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .v        (v),
        .left_val (val_w[i-1]),
        .left_lnk (lnk_w[i-1]),
        .right_val('0),
        .right_lnk(TAIL_LNK),
        .own_val  (val_w[i]),
        .own_lnk  (lnk_w[i]),
        .nxt_val  ()
      );
    end else begin : g_mid
      rmth_cell #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .MAX_FIRST   (MAX_FIRST)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .v        (v),
        .left_val (val_w[i-1]),
        .left_lnk (lnk_w[i-1]),
        .right_val(val_w[i+1]),
        .right_lnk(lnk_w[i+1]),
        .own_val  (val_w[i]),
        .own_lnk  (lnk_w[i]),
        .nxt_val  ()
      );
    end
  end

endmodule

>>> bench/tb_running_median_two_heaps_unit.sv
// Self-checking testbench for the running median unit.
`timescale 1ns / 1ps
module tb_running_median_two_heaps_unit;

  localparam int SW       = rmth_pkg::SAMPLE_WIDTH_DEF;
  localparam int HD       = rmth_pkg::HALF_DEPTH_DEF;
  localparam int CW       = $clog2(2 * HD + 1);
  localparam int MED_W    = SW + 1;
  localparam int IN_W     = ((SW + 7) / 8) * 8;
  localparam int OUT_W    = ((SW + 1 + CW + 7) / 8) * 8;
  localparam int MAX_HELD = 2 * HD;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    longint median_x2;
    int     stored_count;
    bit     rejected;
  } median_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  // Predictor state: both halves kept as ascending sorted lists.
  longint lower_vals[$];
  longint upper_vals[$];
  longint median_x2_q;

  median_result_t pending_medians[$];

  bit no_idle;
  int fault_count;
  int samples_sent;
  int results_checked;
  int rejects_seen;
  int idle_cycles;

  running_median_two_heaps_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void insert_sorted(ref longint vals[$], input longint v);
    int idx;
    idx = 0;
    while (idx < vals.size() && vals[idx] <= v) idx++;
    vals.insert(idx, v);
  endfunction

  function automatic longint lower_top();
    return (lower_vals.size() != 0) ? lower_vals[lower_vals.size()-1] : 64'sd0;
  endfunction

  function automatic longint upper_top();
    return (upper_vals.size() != 0) ? upper_vals[0] : 64'sd0;
  endfunction

  function automatic median_result_t predict_median(input logic [SW-1:0] raw);
    median_result_t r;
    longint s;
    longint moved;
    int     held;
    s    = longint'($signed(raw));
    held = lower_vals.size() + upper_vals.size();
    r.rejected = 1'b0;
    if (held >= MAX_HELD) begin
      r.rejected = 1'b1;
    end else if (lower_vals.size() == upper_vals.size()) begin
      if (2 * s > median_x2_q) begin
        insert_sorted(upper_vals, s);
        median_x2_q = 2 * upper_top();
      end else begin
        insert_sorted(lower_vals, s);
        median_x2_q = 2 * lower_top();
      end
    end else if (upper_vals.size() > lower_vals.size()) begin
      if (2 * s > median_x2_q) begin
        moved = upper_top();
        void'(upper_vals.pop_front());
        insert_sorted(lower_vals, moved);
        insert_sorted(upper_vals, s);
      end else begin
        insert_sorted(lower_vals, s);
      end
      median_x2_q = upper_top() + lower_top();
    end else begin
      if (2 * s > median_x2_q) begin
        insert_sorted(upper_vals, s);
      end else begin
        moved = lower_top();
        void'(lower_vals.pop_back());
        insert_sorted(upper_vals, moved);
        insert_sorted(lower_vals, s);
      end
      median_x2_q = upper_top() + lower_top();
    end
    r.median_x2    = median_x2_q;
    r.stored_count = lower_vals.size() + upper_vals.size();
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SW-1:0] draw_sample();
    int     r;
    longint near_median;
    r = $urandom_range(0, 99);
    near_median = (median_x2_q >>> 1) + longint'($urandom_range(0, 2)) - 1;
    if (r < 30) return $urandom;
    if (r < 55) return SW'($urandom_range(0, 16)) - SW'(8);
    if (r < 63) return {1'b0, {(SW-1){1'b1}}} - SW'($urandom_range(0, 3));
    if (r < 70) return {1'b1, {(SW-1){1'b0}}} + SW'($urandom_range(0, 3));
    // Samples at the current median exercise the strictly-greater split.
    if (r < 85) return SW'(near_median);
    return SW'($urandom_range(0, 2000)) - SW'(1000);
  endfunction

  task automatic send_sample(input logic [SW-1:0] sample);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(sample);
    do @(posedge clk); while (!in_tready);
    pending_medians.push_back(predict_median(sample));
    samples_sent++;
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch on result %0d, %s: expected %0d, got %0d",
               results_checked, field, want, got);
  endtask

  task automatic check_result(input logic [OUT_W-1:0] data, input logic flag);
    median_result_t want;
    longint got_median;
    int     got_count;
    got_median = longint'($signed(data[MED_W-1:0]));
    got_count  = int'(data[MED_W +: CW]);
    if (pending_medians.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("result with no sample pending: median_x2 %0d, count %0d",
                 got_median, got_count);
    end else begin
      want = pending_medians.pop_front();
      if (got_median != want.median_x2)
        report_field("median_x2", want.median_x2, got_median);
      if (got_count != want.stored_count)
        report_field("stored_count", want.stored_count, got_count);
      if (flag !== want.rejected)
        report_field("rejected", want.rejected, flag);
      if (data[OUT_W-1:MED_W+CW] !== '0)
        report_field("fill bits", 0, longint'(data[OUT_W-1:MED_W+CW]));
      if (flag === 1'b1) rejects_seen++;
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: ready bursts broken by stalls of random length.
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Boundary of the first split, both extremes of the doubled median, ties.
  task automatic test_directed();
    logic [SW-1:0] smin;
    logic [SW-1:0] smax;
    smin = {1'b1, {(SW-1){1'b0}}};
    smax = {1'b0, {(SW-1){1'b1}}};
    send_sample('0);
    send_sample(smin);
    send_sample(smin);
    repeat (4) send_sample(smax);
    send_sample('1);
    send_sample(SW'(1));
    send_sample('0);
    repeat (3) send_sample(SW'(5));
    send_sample(-SW'(5));
    send_sample({(SW/2){2'b01}});
    send_sample({(SW/2){2'b10}});
    send_sample(smin + SW'(1));
    send_sample(smax - SW'(1));
    send_sample(smin);
    send_sample(smax);
  endtask

  task automatic test_random_fill(input int count);
    repeat (count) send_sample(draw_sample());
  endtask

  // Items sent with no gaps and results taken with no stalls; the store fills up during this stretch.
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) send_sample(draw_sample());
    no_idle = 1'b0;
  endtask

  task automatic test_store_full(input int count);
    repeat (count) send_sample(draw_sample());
  endtask

  initial begin
    no_idle         = 1'b0;
    fault_count     = 0;
    samples_sent    = 0;
    results_checked = 0;
    rejects_seen    = 0;
    idle_cycles     = 0;
    median_x2_q     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_fill(1000);
    test_back_to_back(120);
    test_store_full(760);

    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d results; the store filled at %0d samples",
             samples_sent, results_checked, MAX_HELD);
    $display("and %0d later samples were flagged as dropped.", rejects_seen);
    if (fault_count == 0 && pending_medians.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
